// ----- design/sphere_box_penetration_macros.svh -----
// Assertion helpers shared by the block's checks.
`ifndef SPHERE_BOX_PENETRATION_MACROS_SVH
`define SPHERE_BOX_PENETRATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBP_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sbp check failed");

// Next-cycle implication, disabled during reset.
`define SBP_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sbp check failed");

`endif

// ----- design/sbp_pkg.sv -----
package sbp_pkg;

   typedef enum logic [1:0] {
      STATUS_CONTACT = 2'd0,
      STATUS_MISS    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   localparam logic [14:0] NORMAL_ONE = 15'd16384;
   localparam int FRONT_STAGE = 0;
   localparam int SQRT_FIRST  = 4;
   localparam int SQRT_STEPS  = 31;
   localparam int DIV_INIT    = SQRT_FIRST + SQRT_STEPS;
   localparam int DIV_FIRST   = DIV_INIT + 1;
   localparam int DIV_STEPS   = 15;
   localparam int NUM_STAGES  = DIV_FIRST + DIV_STEPS;

   typedef struct packed {
      status_type         status;
      logic               valid;
      logic               enclosed;
      logic               far;
      logic               hit;
      logic [2:0]         neg;
      logic [2:0][31:0]   mag;
      logic [2:0][31:0]   hi;
      logic [2:0][61:0]   sq;
      logic [61:0]        rsq;
      logic [30:0]        r;
      logic [63:0]        acc;
      logic [63:0]        root;
      logic [2:0][47:0]   rem;
      logic [2:0][14:0]   q;
      logic [31:0]        depth;
   } pipe_type;

   // Clamp and classify straight from the request fields.
   function automatic pipe_type sbp_front(
      input logic [2:0][31:0] mn,
      input logic [2:0][31:0] mx,
      input logic [2:0][31:0] c,
      input logic [30:0]      r
   );
      pipe_type   y;
      logic [2:0] below;
      logic [2:0] above;
      logic       ok;
      y = '0;
      ok = (r != 31'd0);
      for (int i = 0; i < 3; i++) begin
         below[i] = $signed(c[i]) < $signed(mn[i]);
         above[i] = $signed(c[i]) > $signed(mx[i]);
         if (!($signed(mn[i]) < $signed(mx[i]))) begin
            ok = 1'b0;
         end
      end
      y.valid    = ok;
      y.enclosed = ~|(below | above);
      y.neg      = above;
      y.r        = r;
      y.status   = STATUS_MISS;
      for (int i = 0; i < 3; i++) begin
         y.hi[i] = mx[i] - c[i];
         if (below[i]) begin
            y.mag[i] = mn[i] - c[i];
         end else if (above[i]) begin
            y.mag[i] = c[i] - mx[i];
         end else if (y.enclosed) begin
            y.mag[i] = c[i] - mn[i];
         end else begin
            y.mag[i] = 32'd0;
         end
      end
      return y;
   endfunction

   // Work done by pipeline stage k.
   function automatic pipe_type sbp_step(input int k, input pipe_type x);
      pipe_type    y;
      logic [1:0]  best;
      logic [32:0] sum;
      logic [63:0] bit_v;
      logic [63:0] trial;
      logic [47:0] den;
      int          j;
      y = x;
      best = 2'd0;
      sum = '0;
      bit_v = '0;
      trial = '0;
      den = '0;
      j = 0;
      if (k == 1) begin
         y.far = 1'b0;
         for (int i = 0; i < 3; i++) begin
            if (x.mag[i] >= {1'b0, x.r}) begin
               y.far = 1'b1;
            end
            y.sq[i] = x.mag[i][30:0] * x.mag[i][30:0];
         end
         y.rsq = x.r * x.r;
         if (x.enclosed) begin
            for (int i = 0; i < 3; i++) begin
               y.neg[i] = x.hi[i] < x.mag[i];
               if (x.hi[i] < x.mag[i]) begin
                  y.mag[i] = x.hi[i];
               end
            end
         end
      end else if (k == 2) begin
         y.acc = 64'(x.sq[0]) + 64'(x.sq[1]) + 64'(x.sq[2]);
         if (x.mag[1] < x.mag[0]) begin
            best = 2'd1;
         end
         if (x.mag[2] < x.mag[best]) begin
            best = 2'd2;
         end
         y.root = 64'(x.mag[best]);
         if (x.enclosed) begin
            y.q[best] = NORMAL_ONE;
         end
      end else if (k == 3) begin
         if (!x.valid) begin
            y.status = STATUS_INVALID;
            y.q = '0;
         end else if (x.enclosed) begin
            y.status = STATUS_CONTACT;
            sum = 33'(x.r) + 33'(x.root[31:0]);
            y.depth = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         end else if (x.far || (x.acc >= 64'(x.rsq))) begin
            y.status = STATUS_MISS;
         end else begin
            y.hit = 1'b1;
            y.root = '0;
         end
      end else if (k >= SQRT_FIRST && k < DIV_INIT) begin
         j = DIV_INIT - 1 - k;
         bit_v = 64'd1 << (2 * j);
         trial = x.root + bit_v;
         if (x.hit) begin
            if (x.acc >= trial) begin
               y.acc = x.acc - trial;
               y.root = (x.root >> 1) + bit_v;
            end else begin
               y.root = x.root >> 1;
            end
         end
      end else if (k == DIV_INIT) begin
         if (x.hit) begin
            y.status = STATUS_CONTACT;
            y.depth = 32'(x.r) - x.root[31:0];
            for (int i = 0; i < 3; i++) begin
               y.rem[i] = (48'(x.mag[i]) << 15) + 48'(x.root);
            end
         end
      end else if (k >= DIV_FIRST) begin
         j = NUM_STAGES - 1 - k;
         den = 48'(x.root) << (j + 1);
         if (x.hit) begin
            for (int i = 0; i < 3; i++) begin
               if (x.rem[i] >= den) begin
                  y.rem[i] = x.rem[i] - den;
                  y.q[i][j] = 1'b1;
               end
            end
         end
      end
      return y;
   endfunction

   function automatic logic [15:0] sbp_signed_normal(input logic neg, input logic [14:0] q);
      logic [15:0] m;
      m = {1'b0, q};
      return neg ? (16'd0 - m) : m;
   endfunction

endpackage

// ----- design/sbp_stage.sv -----
module sbp_stage #(
   parameter int STAGE = sbp_pkg::FRONT_STAGE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   input  sbp_pkg::pipe_type up_data,
   output logic              up_ready,
   output logic              dn_valid,
   output sbp_pkg::pipe_type dn_data,
   input  logic              dn_ready
);

   logic              valid_ff;
   sbp_pkg::pipe_type data_ff;
   sbp_pkg::pipe_type data_in;

   // Bubbles collapse: a stage loads whenever it is empty or draining.
   assign up_ready = !valid_ff || dn_ready;
   assign data_in  = sbp_pkg::sbp_step(STAGE, up_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- design/sphere_box_penetration.sv -----
// Sphere versus axis-aligned box contact: one request per clock while the output
// is not stalled. The depth of an outside contact is set by the 31-stage
// bit-per-stage square root of the squared distance, which is followed by the
// 15-stage restoring divider that forms the rounded Q1.14 normals. Empty stages
// close up under rsp_stall, so requests keep being taken until every stage holds
// one.
module sphere_box_penetration (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_box_min_x,
   input  logic [31:0] req_box_min_y,
   input  logic [31:0] req_box_min_z,
   input  logic [31:0] req_box_max_x,
   input  logic [31:0] req_box_max_y,
   input  logic [31:0] req_box_max_z,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [30:0] req_radius,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_normal_x,
   output logic [15:0] rsp_normal_y,
   output logic [15:0] rsp_normal_z,
   output logic [31:0] rsp_depth
);

   `include "sphere_box_penetration_macros.svh"

   localparam int N = sbp_pkg::NUM_STAGES;

   logic              v     [N+1];
   logic              rdy   [N+1];
   sbp_pkg::pipe_type d     [N+1];
   sbp_pkg::pipe_type last;
   logic              rsp_is_contact;
   logic              rsp_normal_zero;
   logic              rsp_zero;

   assign v[0] = req_valid;
   assign d[0] = sbp_pkg::sbp_front(
      {req_box_min_z, req_box_min_y, req_box_min_x},
      {req_box_max_z, req_box_max_y, req_box_max_x},
      {req_center_z, req_center_y, req_center_x},
      req_radius);
   assign req_stall = !rdy[0];
   assign rdy[N] = !rsp_stall;

   for (genvar s = 0; s < N; s++) begin : g_stage
      sbp_stage #(.STAGE(s)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (v[s]),
         .up_data  (d[s]),
         .up_ready (rdy[s]),
         .dn_valid (v[s+1]),
         .dn_data  (d[s+1]),
         .dn_ready (rdy[s+1])
      );
   end

   assign last         = d[N];
   assign rsp_valid    = v[N];
   assign rsp_status   = last.status;
   assign rsp_normal_x = sbp_pkg::sbp_signed_normal(last.neg[0], last.q[0]);
   assign rsp_normal_y = sbp_pkg::sbp_signed_normal(last.neg[1], last.q[1]);
   assign rsp_normal_z = sbp_pkg::sbp_signed_normal(last.neg[2], last.q[2]);
   assign rsp_depth    = last.depth;

   assign rsp_is_contact  = (rsp_status == sbp_pkg::STATUS_CONTACT);
   assign rsp_normal_zero = (rsp_normal_x == 16'd0) && (rsp_normal_y == 16'd0)
                            && (rsp_normal_z == 16'd0);
   assign rsp_zero        = rsp_normal_zero && (rsp_depth == 32'd0);

   `SBP_ASSERT_NOW(a_zero_unless_contact, rsp_valid && !rsp_is_contact, rsp_zero)
   `SBP_ASSERT_NOW(a_contact_has_normal, rsp_valid && rsp_is_contact, !rsp_normal_zero)
   `SBP_ASSERT_NEXT(a_request_enters, req_valid && !req_stall, v[1])

endmodule

// ----- tb/sv/tb_sphere_box_penetration.sv -----
module tb_sphere_box_penetration;

   localparam int LATENCY   = 51;
   localparam int N_RANDOM  = 1700;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic [31:0] mn [3];
      logic [31:0] mx [3];
      logic [31:0] c [3];
      logic [30:0] r;
   } query_type;

   typedef struct {
      sbp_pkg::status_type status;
      logic [15:0] nx, ny, nz;
      logic [31:0] depth;
   } contact_type;

   typedef struct {
      query_type   q;
      logic        has_exp;
      contact_type exp;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [31:0] req_box_min_x, req_box_min_y, req_box_min_z;
   logic [31:0] req_box_max_x, req_box_max_y, req_box_max_z;
   logic [31:0] req_center_x, req_center_y, req_center_z;
   logic [30:0] req_radius;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   logic [15:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [31:0] rsp_depth;

   sphere_box_penetration dut (.*);

   contact_type expected_contacts [$];
   row_type     directed [$];
   int          errors = 0;
   int          cycle = 0;
   int          n_sent = 0, n_checked = 0, n_hits = 0;
   bit          hold_off = 0;
   bit          calm = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] unit_comp(input longint d, input logic [63:0] dlen);
      logic [63:0] mag, qv;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      qv = (mag * 64'd16384 * 2 + dlen) / (dlen * 2);
      return (d < 0) ? 16'(-qv) : 16'(qv);
   endfunction

   function automatic contact_type predict_contact(input query_type q);
      contact_type y;
      longint      mn [3], mx [3], c [3], d [3], p, fd;
      logic [63:0] r, a, dsq, dlen, best, dep;
      bit          ok, far;
      int          face, ax;
      y = '{sbp_pkg::STATUS_CONTACT, 16'd0, 16'd0, 16'd0, 32'd0};
      r = 64'(q.r);
      ok = (q.r != 0);
      far = 0;
      dsq = 0;
      for (int i = 0; i < 3; i++) begin
         mn[i] = longint'($signed(q.mn[i]));
         mx[i] = longint'($signed(q.mx[i]));
         c[i] = longint'($signed(q.c[i]));
         if (!(mn[i] < mx[i])) ok = 0;
      end
      if (!ok) begin
         y.status = sbp_pkg::STATUS_INVALID;
         return y;
      end
      for (int i = 0; i < 3; i++) begin
         p = c[i] < mn[i] ? mn[i] : (c[i] > mx[i] ? mx[i] : c[i]);
         d[i] = p - c[i];
         a = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
         if (a >= r) far = 1;
         else dsq += a * a;
      end
      if (far || (dsq > 0 && dsq >= r * r)) begin
         y.status = sbp_pkg::STATUS_MISS;
      end else if (dsq > 0) begin
         dlen = isqrt(dsq);
         y.nx = unit_comp(d[0], dlen);
         y.ny = unit_comp(d[1], dlen);
         y.nz = unit_comp(d[2], dlen);
         y.depth = 32'(r - dlen);
      end else begin
         best = 64'(c[0] - mn[0]);
         face = 0;
         for (int i = 1; i < 6; i++) begin
            ax = i >> 1;
            fd = (i & 1) ? (mx[ax] - c[ax]) : (c[ax] - mn[ax]);
            if (64'(fd) < best) begin
               best = 64'(fd);
               face = i;
            end
         end
         case (face >> 1)
            0: y.nx = (face & 1) ? -16'sd16384 : 16'sd16384;
            1: y.ny = (face & 1) ? -16'sd16384 : 16'sd16384;
            default: y.nz = (face & 1) ? -16'sd16384 : 16'sd16384;
         endcase
         dep = r + best;
         y.depth = (dep > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(dep);
      end
      return y;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch #%0d at cycle %0d: %s got %0h expected %0h",
               n_checked, cycle, what, got, want);
      errors++;
   endtask

   function automatic query_type make_query(input longint mnx, mny, mnz, mxx, mxy, mxz,
                                            input longint cx, cy, cz, input longint r);
      query_type q;
      q.mn[0] = 32'(mnx); q.mn[1] = 32'(mny); q.mn[2] = 32'(mnz);
      q.mx[0] = 32'(mxx); q.mx[1] = 32'(mxy); q.mx[2] = 32'(mxz);
      q.c[0] = 32'(cx); q.c[1] = 32'(cy); q.c[2] = 32'(cz);
      q.r = 31'(r);
      return q;
   endfunction

   function automatic logic [31:0] rand_coord(input int span);
      return 32'($signed($urandom_range(2 * span, 0)) - span);
   endfunction

   // mostly boxes near a sphere so the hit and inside paths see traffic
   function automatic query_type random_query();
      query_type   q;
      int          kind, span;
      logic [31:0] lo, ext;
      kind = $urandom_range(99);
      span = 1 << $urandom_range(22, 8);
      for (int i = 0; i < 3; i++) begin
         if (kind < 6) begin
            q.mn[i] = $urandom;
            q.mx[i] = $urandom;
            q.c[i] = $urandom;
         end else begin
            lo = rand_coord(span);
            ext = $urandom_range(span, 1);
            q.mn[i] = lo;
            q.mx[i] = lo + ext;
            q.c[i] = lo + rand_coord(span);
            if (kind < 10 && i == 0) q.mx[i] = lo - $urandom_range(1, 0);
         end
      end
      if (kind < 6) q.r = 31'($urandom);
      else if (kind < 12) q.r = 31'($urandom_range(3, 0));
      else if (kind < 16) q.r = 31'h7FFF_FFFF - 31'($urandom_range(1000));
      else q.r = 31'($urandom_range(2 * span, 1));
      return q;
   endfunction

   task automatic send_query(input query_type q);
      req_valid <= 1'b1;
      req_box_min_x <= q.mn[0]; req_box_min_y <= q.mn[1]; req_box_min_z <= q.mn[2];
      req_box_max_x <= q.mx[0]; req_box_max_y <= q.mx[1]; req_box_max_z <= q.mx[2];
      req_center_x <= q.c[0]; req_center_y <= q.c[1]; req_center_z <= q.c[2];
      req_radius <= q.r;
      do @(posedge clock); while (req_stall);
      expected_contacts.push_back(predict_contact(q));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic idle_gap();
      if (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // result check
   always @(posedge clock) begin
      contact_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_contacts.size() == 0) begin
            report("unexpected response", rsp_status, 0);
         end else begin
            e = expected_contacts.pop_front();
            if (rsp_status != e.status) report("status", rsp_status, e.status);
            if (rsp_normal_x != e.nx) report("normal_x", rsp_normal_x, e.nx);
            if (rsp_normal_y != e.ny) report("normal_y", rsp_normal_y, e.ny);
            if (rsp_normal_z != e.nz) report("normal_z", rsp_normal_z, e.nz);
            if (rsp_depth != e.depth) report("depth", rsp_depth, e.depth);
            if (e.status == sbp_pkg::STATUS_CONTACT && e.depth != 0) n_hits++;
         end
         n_checked++;
      end
   end

   // receiver stall, with one long hold-off so the pipe fills
   initial begin
      int held;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < 300; held++) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_off = 0;
         end else begin
            rsp_stall <= (!calm && $urandom_range(99) < 13);
         end
      end
   end

   always @(posedge clock) begin
      cycle++;
      if (cycle > MAX_CYCLE) begin
         $display("timeout at cycle %0d", cycle);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      row_type     row;
      query_type   q;
      contact_type e;
      int          waited;
      req_valid = 0;
      req_box_min_x = 0; req_box_min_y = 0; req_box_min_z = 0;
      req_box_max_x = 0; req_box_max_y = 0; req_box_max_z = 0;
      req_center_x = 0; req_center_y = 0; req_center_z = 0;
      req_radius = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: expected typed where obvious, else predictor
      e = '{sbp_pkg::STATUS_INVALID, 16'd0, 16'd0, 16'd0, 32'd0};
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, 0, 0, 0, 0), 1, e});
      directed.push_back('{make_query(0, 0, 0, 0, 65536, 65536, 0, 0, 0, 100), 1, e});
      directed.push_back('{make_query(0, 0, 0, 65536, -5, 65536, 0, 0, 0, 100), 1, e});
      directed.push_back('{make_query(0, 0, 9, 65536, 65536, 9, 0, 0, 0, 100), 1, e});
      directed.push_back('{make_query(32'sh7FFFFFFF, 0, 0, -32'sh80000000, 1, 1, 0, 0, 0, 1),
                           1, e});
      e = '{sbp_pkg::STATUS_MISS, 16'd0, 16'd0, 16'd0, 32'd0};
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, 1000000, 0, 0, 65536),
                           1, e});
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, -65536, 0, 0, 65536),
                           1, e});
      directed.push_back('{make_query(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                           32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           0, 0, 0, 0), 1, '{sbp_pkg::STATUS_INVALID, 0, 0, 0, 0}});
      // inside the widest box, largest radius: +x face is nearest, deepest depth
      e = '{sbp_pkg::STATUS_CONTACT, 16'hC000, 16'd0, 16'd0, 32'hFFFF_FFFE};
      directed.push_back('{make_query(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                           32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           0, 0, 0, 31'h7FFFFFFF), 1, e});
      // centre at min corner: -x face ties win, depth = radius
      e = '{sbp_pkg::STATUS_CONTACT, 16'd16384, 16'd0, 16'd0, 32'd7};
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, 0, 0, 0, 7), 1, e});
      // centre at max corner: +x face
      e = '{sbp_pkg::STATUS_CONTACT, 16'hC000, 16'd0, 16'd0, 32'd7};
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, 65536, 65536, 65536, 7),
                           1, e});
      directed.push_back('{make_query(0, 0, 0, 100, 100, 100, 50, 10, 50, 9), 0, e});
      directed.push_back('{make_query(0, 0, 0, 100, 100, 100, 50, 95, 50, 9), 0, e});
      directed.push_back('{make_query(0, 0, 0, 100, 100, 100, 50, 50, 3, 9), 0, e});
      directed.push_back('{make_query(0, 0, 0, 100, 100, 100, 50, 50, 98, 9), 0, e});
      // outside, single axis: exact normal
      e = '{sbp_pkg::STATUS_CONTACT, 16'hC000, 16'd0, 16'd0, 32'd60000};
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, 71072, 100, 100, 65536),
                           1, e});
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, -3000, -4000, 100,
                           65536), 0, e});
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, -3000, -4000, -5000,
                           65536), 0, e});
      directed.push_back('{make_query(0, 0, 0, 65536, 65536, 65536, 70000, 70000, 70000,
                           10000), 0, e});
      directed.push_back('{make_query(-32'sh80000000, 0, 0, -32'sh7FFFFFFF, 1, 1,
                           32'sh7FFFFFFF, 0, 0, 31'h7FFFFFFF), 0, e});
      directed.push_back('{make_query(0, 0, 0, 1, 1, 1, 2, 2, 2, 2), 0, e});
      directed.push_back('{make_query(0, 0, 0, 1, 1, 1, 3, 2, 1, 2), 0, e});

      calm = 1;
      foreach (directed[i]) begin
         row = directed[i];
         send_query(row.q);
         if (row.has_exp) expected_contacts[$] = row.exp;
      end

      // random, first stretch with no idling
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k == 300) calm = 0;
         if (k == 700) hold_off = 1;
         q = random_query();
         idle_gap();
         send_query(q);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (expected_contacts.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(negedge clock);
      $display("sent %0d requests (%0d directed), checked %0d responses, %0d contacts",
               n_sent, directed.size(), n_checked, n_hits);
      $display("covered invalid boxes, misses, outside and inside contacts, long output stall");
      if (errors == 0 && expected_contacts.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d errors, %0d responses missing", errors, expected_contacts.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sphere_box_penetration.f -----
+incdir+design
design/sbp_pkg.sv
design/sbp_stage.sv
design/sphere_box_penetration.sv
tb/sv/tb_sphere_box_penetration.sv
